// File: sv/rcm_pkg.sv
// Shared constants for the range lower-to-minimum / range minimum store.
`default_nettype none
package rcm_pkg;
  // Width of the one-based position fields and of the leaf count register.
  localparam int POS_BITS = 11;
  // Request kinds.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;
  // Value of a position that was never lowered.
  localparam logic [63:0] INF_VALUE = 64'd1000000000000;
  // Reset value of the leaf count register.
  localparam logic [POS_BITS-1:0] LEAVES_RESET = 11'd1024;
endpackage
`default_nettype wire

// File: sv/rcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rcm_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// File: sv/range_chmin_range_min_tree_unit.sv
// Top level of the range lower-to-minimum / range minimum store.
`default_nettype none
// The store keeps one value per position in a single RAM of N_LEAVES words and
// walks a request's clamped range one position per cycle through a read,
// modify and write-back pipeline. No new request is accepted until the scan
// has closed, which is after the last read through the single RAM read port
// has come back. A query then holds its result in the output state for as long
// as the result is stalled. An empty update leaves the store idle, and an
// empty query goes straight to its result.
// A query's result waits in an output register until taken, and the next
// request is accepted once that result has left. After reset, and after every
// write of the leaf count register, a clearing pass over all N_LEAVES words sets
// every position to 1000000000000; no request is accepted during it.
module range_chmin_range_min_tree_unit
  import rcm_pkg::*;
#(
  parameter int N_LEAVES   = 1024,
  parameter int VALUE_BITS = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [POS_BITS-1:0]   cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_kind,
  input  wire logic [POS_BITS-1:0]   in_range_low,
  input  wire logic [POS_BITS-1:0]   in_range_high,
  input  wire logic [VALUE_BITS-1:0] in_new_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [VALUE_BITS-1:0] out_min_value
);
  localparam int AW = $clog2(N_LEAVES);
  localparam logic [VALUE_BITS-1:0] INF_V = VALUE_BITS'(INF_VALUE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(N_LEAVES - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [POS_BITS-1:0]     leaves_cfg_r;
  logic [AW-1:0]           clr_r, clr_nxt;
  logic [POS_BITS-1:0]     cur_r, cur_nxt;
  logic [POS_BITS-1:0]     hi_r, hi_nxt;
  logic                    kind_r, kind_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;
  logic                    d1_r, d1_nxt;
  logic [AW-1:0]           d1_addr_r, d1_addr_nxt;

  logic [POS_BITS-1:0]     leaves, lo_c, hi_c;
  logic                    empty, accept, issue;
  logic [AW-1:0]           rd_addr;
  logic [VALUE_BITS-1:0]   rd_data, upd_data;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [VALUE_BITS-1:0]   wr_data;

  // Leaf count saturates at the store size; the request range is clamped to it.
  assign leaves = (32'(leaves_cfg_r) > N_LEAVES) ? POS_BITS'(N_LEAVES) : leaves_cfg_r;
  assign lo_c   = (in_range_low == '0) ? POS_BITS'(1) : in_range_low;
  assign hi_c   = (in_range_high > leaves) ? leaves : in_range_high;
  assign empty  = (leaves == '0) || (lo_c > hi_c);

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign out_min_value = acc_r;

  // Read side of the scan: one position per cycle up to the clamped end.
  assign issue   = (state_r == ST_SCAN) && (cur_r <= hi_r) && (cur_r != '0);
  assign rd_addr = AW'(32'(cur_r) - 32'd1);

  // Write side: the clearing pass, or the lowered value in the cycle after its read.
  assign upd_data = (rd_data < val_r) ? rd_data : val_r;
  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = INF_V;
    end else begin
      wr_en   = d1_r && (kind_r == KIND_UPDATE);
      wr_addr = d1_addr_r;
      wr_data = upd_data;
    end
  end

  rcm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (N_LEAVES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer for clearing, scanning and result hand-off.
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    cur_nxt     = cur_r;
    hi_nxt      = hi_r;
    kind_nxt    = kind_r;
    val_nxt     = val_r;
    acc_nxt     = acc_r;
    d1_nxt      = issue;
    d1_addr_nxt = rd_addr;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind;
          val_nxt  = in_new_value;
          acc_nxt  = INF_V;
          cur_nxt  = lo_c;
          hi_nxt   = hi_c;
          if (empty) begin
            state_nxt = (in_kind == KIND_QUERY) ? ST_OUT : ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cur_nxt = cur_r + POS_BITS'(1);
        end
        if (d1_r && (kind_r == KIND_QUERY) && (rd_data < acc_r)) begin
          acc_nxt = rd_data;
        end
        if (!issue && !d1_r) begin
          state_nxt = (kind_r == KIND_QUERY) ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // A leaf count write restarts the clearing pass.
    if (cfg_wr_en) begin
      state_nxt = ST_CLEAR;
      clr_nxt   = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      d1_r         <= 1'b0;
      leaves_cfg_r <= LEAVES_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      d1_r    <= d1_nxt;
      if (cfg_wr_en) begin
        leaves_cfg_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    hi_r      <= hi_nxt;
    kind_r    <= kind_nxt;
    val_r     <= val_nxt;
    acc_r     <= acc_nxt;
    d1_addr_r <= d1_addr_nxt;
  end

`ifndef SYNTHESIS
  // The RAM is written only while clearing or scanning.
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_CLEAR || state_r == ST_SCAN))
    else $error("store written outside clearing or scanning");
  // A leaf count write always starts a clearing pass from the first word.
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (state_r == ST_CLEAR && clr_r == '0))
    else $error("leaf count write did not restart clearing");
  // A scan ends only after the last read has come back.
  a_scan_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && d1_r && !cfg_wr_en) |=> (state_r == ST_SCAN))
    else $error("scan left with a read in flight");
`endif
endmodule
`default_nettype wire
